>>> rtl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// JSON string unescape package
// Result codes, the front-to-back request type and shared sizes.
// ----------------------------------------------------------------------------
package jsu_pkg;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [3:0] {
      CODE_DATA     = 4'd0,
      CODE_CLOSED   = 4'd1,
      CODE_NOQUOTE  = 4'd2,
      CODE_CONTROL  = 4'd3,
      CODE_ESCCUT   = 4'd4,
      CODE_BADESC   = 4'd5,
      CODE_HEXSHORT = 4'd6,
      CODE_BADHEX   = 4'd7,
      CODE_NOLOW    = 4'd8,
      CODE_BADLOW   = 4'd9,
      CODE_LONELOW  = 4'd10,
      CODE_UNCLOSED = 4'd11
   } code_type;

   // One classified input byte: up to four data bytes, then an optional code.
   typedef struct packed {
      logic [2:0]      data_count;
      logic [3:0][7:0] data;
      logic            term_valid;
      code_type        term_code;
   } cmd_type;

endpackage

>>> rtl/json_string_unescape_utf8.sv
// ----------------------------------------------------------------------------
// JSON string unescape to UTF-8
// Decodes a quoted JSON string byte stream into UTF-8 bytes and status codes.
//
//   channel   direction  handshake             payload
//   req       in         req_valid/req_ready   req_byte_in, req_end_of_text
//   rsp       out        rsp_valid/rsp_ready   rsp_byte_out, rsp_code,
//                                              rsp_last_of_run
//
// One request per cycle enters the front end while req_ready is high; each
// gives 0 to 5 results, one per cycle from the back end while rsp is ready.
// Sustained rate is one request per cycle while each gives at most one result
// and rsp is ready; the back end's single output register sets the rate
// otherwise. Reset is synchronous and clears the parser and the queue.
// A stalled rsp channel fills the queue, then drops req_ready.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8 #(
   parameter int QueueDepth = jsu_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_byte_in,
   input  logic       req_end_of_text,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_byte_out,
   output logic [3:0] rsp_code,
   output logic       rsp_last_of_run
);

   logic             push;
   logic             pop;
   logic             q_full;
   logic             q_empty;
   jsu_pkg::cmd_type push_cmd;
   jsu_pkg::cmd_type q_head;

   jsu_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_byte_in     (req_byte_in),
      .req_end_of_text (req_end_of_text),
      .q_full          (q_full),
      .push            (push),
      .push_cmd        (push_cmd)
   );

   jsu_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .full     (q_full),
      .empty    (q_empty),
      .head     (q_head)
   );

   jsu_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_head          (q_head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_byte_out    (rsp_byte_out),
      .rsp_code        (rsp_code),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

>>> rtl/jsu_front.sv
// ----------------------------------------------------------------------------
// JSON string unescape front end
// Parses input bytes, decodes escapes and builds at most one request per byte.
// ----------------------------------------------------------------------------
module jsu_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_byte_in,
   input  logic             req_end_of_text,
   input  logic             q_full,
   output logic             push,
   output jsu_pkg::cmd_type push_cmd
);

   typedef enum logic [2:0] {
      PH_WAIT = 3'd0,
      PH_BODY = 3'd1,
      PH_ESC  = 3'd2,
      PH_HEX1 = 3'd3,
      PH_BSL  = 3'd4,
      PH_LETU = 3'd5,
      PH_HEX2 = 3'd6
   } phase_type;

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5c;
   localparam logic [7:0] CH_U      = 8'h75;

   phase_type   phase_ff, phase_in;
   logic [2:0]  hex_count_ff, hex_count_in;
   logic [15:0] hex_accum_ff, hex_accum_in;
   logic [9:0]  high_half_ff, high_half_in;
   logic        bad_ff, bad_in;

   logic        accept;
   logic [7:0]  c;
   logic        last;
   logic [3:0]  digit;
   logic        digit_ok;
   logic [15:0] hex_new;
   logic [2:0]  count_new;
   logic        bad_new;
   logic [10:0] pair_hi;
   logic [20:0] enc_cp;
   logic [2:0]  enc_count;
   logic [3:0][7:0] enc_bytes;
   jsu_pkg::cmd_type cmd;

   assign c         = req_byte_in;
   assign last      = req_end_of_text;
   assign req_ready = !q_full;
   assign accept    = req_valid && !q_full;

   always_comb begin
      digit_ok = 1'b1;
      digit    = 4'd0;
      if (c inside {[8'h30:8'h39]}) begin
         digit = c[3:0];
      end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
         digit = c[3:0] + 4'd9;
      end else begin
         digit_ok = 1'b0;
      end
   end

   assign hex_new   = {hex_accum_ff[11:0], digit};
   assign count_new = hex_count_ff + 3'd1;
   assign bad_new   = bad_ff || !digit_ok;
   assign pair_hi   = {1'b0, high_half_ff} + 11'h040;
   assign enc_cp    = (phase_ff == PH_HEX2) ? {pair_hi, hex_new[9:0]} : {5'd0, hex_new};

   always_comb begin
      enc_bytes = '0;
      if (enc_cp <= 21'h7f) begin
         enc_count    = 3'd1;
         enc_bytes[0] = enc_cp[7:0];
      end else if (enc_cp <= 21'h7ff) begin
         enc_count    = 3'd2;
         enc_bytes[0] = {3'b110, enc_cp[10:6]};
         enc_bytes[1] = {2'b10, enc_cp[5:0]};
      end else if (enc_cp <= 21'hffff) begin
         enc_count    = 3'd3;
         enc_bytes[0] = {4'b1110, enc_cp[15:12]};
         enc_bytes[1] = {2'b10, enc_cp[11:6]};
         enc_bytes[2] = {2'b10, enc_cp[5:0]};
      end else begin
         enc_count    = 3'd4;
         enc_bytes[0] = {5'b11110, enc_cp[20:18]};
         enc_bytes[1] = {2'b10, enc_cp[17:12]};
         enc_bytes[2] = {2'b10, enc_cp[11:6]};
         enc_bytes[3] = {2'b10, enc_cp[5:0]};
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      hex_count_in = hex_count_ff;
      hex_accum_in = hex_accum_ff;
      high_half_in = high_half_ff;
      bad_in       = bad_ff;
      cmd          = '0;
      cmd.term_code = jsu_pkg::CODE_DATA;
      case (phase_ff)
         PH_WAIT: begin
            if (c == CH_QUOTE) begin
               phase_in = PH_BODY;
            end else begin
               cmd.term_valid = 1'b1;
               cmd.term_code  = jsu_pkg::CODE_NOQUOTE;
            end
         end
         PH_BODY: begin
            if (c == CH_QUOTE) begin
               cmd.term_valid = 1'b1;
               cmd.term_code  = jsu_pkg::CODE_CLOSED;
               phase_in       = PH_WAIT;
            end else if (c < 8'h20) begin
               cmd.term_valid = 1'b1;
               cmd.term_code  = jsu_pkg::CODE_CONTROL;
               phase_in       = PH_WAIT;
            end else if (c == CH_BSLASH) begin
               if (last) begin
                  cmd.term_valid = 1'b1;
                  cmd.term_code  = jsu_pkg::CODE_ESCCUT;
                  phase_in       = PH_WAIT;
               end else begin
                  phase_in = PH_ESC;
               end
            end else begin
               cmd.data_count = 3'd1;
               cmd.data[0]    = c;
            end
         end
         PH_ESC: begin
            phase_in       = PH_BODY;
            cmd.data_count = 3'd1;
            case (c)
               8'h22, 8'h5c, 8'h2f: cmd.data[0] = c;
               8'h62: cmd.data[0] = 8'h08;
               8'h66: cmd.data[0] = 8'h0c;
               8'h6e: cmd.data[0] = 8'h0a;
               8'h72: cmd.data[0] = 8'h0d;
               8'h74: cmd.data[0] = 8'h09;
               CH_U: begin
                  cmd.data_count = 3'd0;
                  if (last) begin
                     cmd.term_valid = 1'b1;
                     cmd.term_code  = jsu_pkg::CODE_HEXSHORT;
                     phase_in       = PH_WAIT;
                  end else begin
                     phase_in     = PH_HEX1;
                     hex_count_in = 3'd0;
                     hex_accum_in = 16'd0;
                     bad_in       = 1'b0;
                  end
               end
               default: begin
                  cmd.data_count = 3'd0;
                  cmd.term_valid = 1'b1;
                  cmd.term_code  = jsu_pkg::CODE_BADESC;
                  phase_in       = PH_WAIT;
               end
            endcase
         end
         PH_HEX1, PH_HEX2: begin
            hex_accum_in = hex_new;
            hex_count_in = count_new;
            bad_in       = bad_new;
            if (count_new < 3'd4) begin
               if (last) begin
                  cmd.term_valid = 1'b1;
                  cmd.term_code  = jsu_pkg::CODE_HEXSHORT;
                  phase_in       = PH_WAIT;
               end
            end else if (bad_new) begin
               cmd.term_valid = 1'b1;
               cmd.term_code  = jsu_pkg::CODE_BADHEX;
               phase_in       = PH_WAIT;
            end else if (phase_ff == PH_HEX1) begin
               if (hex_new[15:10] == 6'b110110) begin
                  high_half_in = hex_new[9:0];
                  if (last) begin
                     cmd.term_valid = 1'b1;
                     cmd.term_code  = jsu_pkg::CODE_NOLOW;
                     phase_in       = PH_WAIT;
                  end else begin
                     phase_in = PH_BSL;
                  end
               end else if (hex_new[15:10] == 6'b110111) begin
                  cmd.term_valid = 1'b1;
                  cmd.term_code  = jsu_pkg::CODE_LONELOW;
                  phase_in       = PH_WAIT;
               end else begin
                  cmd.data_count = enc_count;
                  cmd.data       = enc_bytes;
                  phase_in       = PH_BODY;
               end
            end else begin
               if (hex_new[15:10] != 6'b110111) begin
                  cmd.term_valid = 1'b1;
                  cmd.term_code  = jsu_pkg::CODE_BADLOW;
                  phase_in       = PH_WAIT;
               end else begin
                  cmd.data_count = enc_count;
                  cmd.data       = enc_bytes;
                  phase_in       = PH_BODY;
               end
            end
         end
         PH_BSL: begin
            if (c != CH_BSLASH || last) begin
               cmd.term_valid = 1'b1;
               cmd.term_code  = jsu_pkg::CODE_NOLOW;
               phase_in       = PH_WAIT;
            end else begin
               phase_in = PH_LETU;
            end
         end
         PH_LETU: begin
            if (c != CH_U) begin
               cmd.term_valid = 1'b1;
               cmd.term_code  = jsu_pkg::CODE_NOLOW;
               phase_in       = PH_WAIT;
            end else if (last) begin
               cmd.term_valid = 1'b1;
               cmd.term_code  = jsu_pkg::CODE_HEXSHORT;
               phase_in       = PH_WAIT;
            end else begin
               phase_in     = PH_HEX2;
               hex_count_in = 3'd0;
               hex_accum_in = 16'd0;
               bad_in       = 1'b0;
            end
         end
         default: begin
            cmd.term_valid = 1'b1;
            cmd.term_code  = jsu_pkg::CODE_NOQUOTE;
            phase_in       = PH_WAIT;
         end
      endcase
      // end of text inside a string
      if (last && phase_in != PH_WAIT) begin
         cmd.term_valid = 1'b1;
         cmd.term_code  = jsu_pkg::CODE_UNCLOSED;
         phase_in       = PH_WAIT;
      end
   end

   assign push     = accept && (cmd.data_count != 3'd0 || cmd.term_valid);
   assign push_cmd = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_WAIT;
         hex_count_ff <= 3'd0;
         hex_accum_ff <= 16'd0;
         high_half_ff <= 10'd0;
         bad_ff       <= 1'b0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         hex_count_ff <= hex_count_in;
         hex_accum_ff <= hex_accum_in;
         high_half_ff <= high_half_in;
         bad_ff       <= bad_in;
      end
   end

endmodule

>>> rtl/jsu_queue.sv
// ----------------------------------------------------------------------------
// JSON string unescape request queue
// Small FIFO of decoded requests between the front end and the back end.
// ----------------------------------------------------------------------------
module jsu_queue #(
   parameter int Depth = jsu_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  jsu_pkg::cmd_type push_cmd,
   input  logic             pop,
   output logic             full,
   output logic             empty,
   output jsu_pkg::cmd_type head
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

   jsu_pkg::cmd_type mem [Depth];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;

   assign full  = (count_ff == FullCnt);
   assign empty = (count_ff == '0);
   assign head  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CntW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> rtl/jsu_back.sv
// ----------------------------------------------------------------------------
// JSON string unescape back end
// Expands each request into result items and drives the output register.
// ----------------------------------------------------------------------------
module jsu_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   input  jsu_pkg::cmd_type q_head,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [7:0]       rsp_byte_out,
   output logic [3:0]       rsp_code,
   output logic             rsp_last_of_run
);

   logic [2:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] byte_ff, byte_in;
   logic [3:0] code_ff, code_in;
   logic       last_ff, last_in;

   logic [2:0] total;
   logic       load;
   logic       is_last;

   assign total   = q_head.data_count + {2'b00, q_head.term_valid};
   assign load    = !q_empty && (!rsp_valid_ff || rsp_ready);
   assign is_last = (idx_ff == total - 3'd1);
   assign pop     = load && is_last;

   always_comb begin
      idx_in       = idx_ff;
      byte_in      = byte_ff;
      code_in      = code_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (load) begin
         rsp_valid_in = 1'b1;
         last_in      = is_last;
         idx_in       = is_last ? 3'd0 : idx_ff + 3'd1;
         if (idx_ff < q_head.data_count) begin
            byte_in = q_head.data[idx_ff[1:0]];
            code_in = jsu_pkg::CODE_DATA;
         end else begin
            byte_in = 8'd0;
            code_in = q_head.term_code;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      code_ff <= code_in;
      last_ff <= last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_byte_out    = byte_ff;
   assign rsp_code        = code_ff;
   assign rsp_last_of_run = last_ff;

endmodule

>>> rtl/jsu_checker.sv
// ----------------------------------------------------------------------------
// JSON string unescape port checker
// Checks result stream properties seen at the top-level ports.
// ----------------------------------------------------------------------------
module jsu_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_byte_out,
   input logic [3:0] rsp_code,
   input logic       rsp_last_of_run
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_byte_out)
         && $stable(rsp_code) && $stable(rsp_last_of_run))
      else $error("rsp changed while stalled");

   a_code_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_code != jsu_pkg::CODE_DATA |-> rsp_last_of_run)
      else $error("status code not last of run");

   a_code_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_code != jsu_pkg::CODE_DATA |-> rsp_byte_out == 8'd0)
      else $error("status code with nonzero byte");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (.*);
